>>> rtl/mpab_pkg.sv
// ----------------------------------------------------------------------------
// mpab_pkg: shared types and constants of the max pool with argmax block
// sizes, word structs, configuration view and small helper functions
// ----------------------------------------------------------------------------
package mpab_pkg;

	localparam int MAX_HEIGHT   = 64;
	localparam int MAX_WIDTH    = 64;
	localparam int MAX_CHANNELS = 64;
	localparam int MAX_POOL     = 4;
	localparam int POOL_HI      = (MAX_POOL < 4) ? MAX_POOL : 4;

	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int CHAN_W = $clog2(MAX_CHANNELS);
	localparam int WROW_W = $clog2(MAX_HEIGHT / 2);
	localparam int WCOL_W = $clog2(MAX_WIDTH / 2);

	localparam int PART_DEPTH = (MAX_WIDTH / 2) * MAX_CHANNELS;
	localparam int ARG_DEPTH  = (MAX_HEIGHT / 2) * (MAX_WIDTH / 2) * MAX_CHANNELS;
	localparam int PART_AW    = $clog2(PART_DEPTH);
	localparam int ARG_AW     = $clog2(ARG_DEPTH);

	localparam int VAL_W      = 16;
	localparam int OFF_W      = 4;
	localparam int WIN_W      = 2;
	localparam int DIM_W      = 7;
	localparam int POOL_W     = 3;
	localparam int PDIM_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int PART_W     = OFF_W + VAL_W;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic OP_FORWARD  = 1'b0;
	localparam logic OP_BACKWARD = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_HEIGHT = 2'd0,
		REG_IN_WIDTH  = 2'd1,
		REG_CHANNELS  = 2'd2,
		REG_POOL_SIZE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                    operation;
		logic signed [VAL_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [WIN_W-1:0]        window_row;
		logic [WIN_W-1:0]        window_col;
		logic                    last_of_run;
	} out_word_t;

	typedef struct packed {
		logic [DIM_W-1:0]  height;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  chans;
		logic [POOL_W-1:0] pool;
		logic [PDIM_W-1:0] pooled_h;
		logic [PDIM_W-1:0] pooled_w;
	} cfg_t;

	typedef struct packed {
		logic                    bwd;
		logic signed [VAL_W-1:0] value;
		logic [OFF_W-1:0]        off;
	} cmd_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lo, input logic [DIM_W-1:0] hi);
		if (v < lo)
			clamp_dim = lo;
		else if (v > hi)
			clamp_dim = hi;
		else
			clamp_dim = v;
	endfunction

	// floor(x / p) for p in 2..4; divide by three through a reciprocal
	function automatic logic [PDIM_W-1:0] div_pool(input logic [DIM_W-1:0] x,
			input logic [POOL_W-1:0] p);
		logic [DIM_W+8-1:0] prod;
		prod = (DIM_W + 8)'(x) * (DIM_W + 8)'(171);
		case (p)
			3'd3: div_pool = PDIM_W'(prod >> 9);
			3'd4: div_pool = PDIM_W'(x >> 2);
			default: div_pool = PDIM_W'(x >> 1);
		endcase
	endfunction

endpackage

>>> rtl/max_pool_with_argmax_backprop.sv
// ----------------------------------------------------------------------------
// max_pool_with_argmax_backprop: max pooling with argmax mask and gradient routing
//
// Input is a queue: push a word while full is low. A forward word is one
// activation in row, column, channel raster order; the last element of each
// complete pool_size square window yields one word with the window maximum.
// A backward word is the gradient of one pooled output, in pooled raster
// order; it yields pool_size*pool_size words, row-major within the window,
// the gradient at the stored argmax and zero elsewhere, last_of_run set on
// the final one. Output is a queue: read while empty is low, pop to advance.
// A word passes the read stage, command queue and output register. Forward
// words are taken one per cycle while full is low; a backward word holds the
// result side while its words leave the output expander, one word per cycle
// while pop is high. When pop stays low the output register holds its word
// and the command queue fills, then full rises. Reset clears positions and
// restores a 64x64x64 map with 2x2 windows; any configuration write also
// restarts both positions. The argmax store holds no reset state.
// ----------------------------------------------------------------------------
module max_pool_with_argmax_backprop (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  mpab_pkg::in_word_t                  item,
	output logic                                empty,
	input  logic                                pop,
	output mpab_pkg::out_word_t                 result,
	input  logic                                cfg_we,
	input  logic [mpab_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [mpab_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mpab_pkg::*;

	logic [DIM_W-1:0]  height_q, width_q, chans_q;
	logic [POOL_W-1:0] pool_q;
	cfg_t              cfg;
	logic              cmd_push, cmd_valid, cmd_pop;
	cmd_t              cmd_in, cmd_out;
	logic [CMDQ_CNT_W-1:0] cmd_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= DIM_W'(MAX_HEIGHT);
			width_q  <= DIM_W'(MAX_WIDTH);
			chans_q  <= DIM_W'(MAX_CHANNELS);
			pool_q   <= POOL_W'(2);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_IN_HEIGHT: height_q <= clamp_dim(cfg_data, DIM_W'(2), DIM_W'(MAX_HEIGHT));
				REG_IN_WIDTH:  width_q  <= clamp_dim(cfg_data, DIM_W'(2), DIM_W'(MAX_WIDTH));
				REG_CHANNELS:  chans_q  <= clamp_dim(cfg_data, DIM_W'(1), DIM_W'(MAX_CHANNELS));
				REG_POOL_SIZE: pool_q   <= POOL_W'(clamp_dim(DIM_W'(cfg_data[POOL_W-1:0]),
					DIM_W'(2), DIM_W'(POOL_HI)));
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.height   = height_q;
		cfg.width    = width_q;
		cfg.chans    = chans_q;
		cfg.pool     = pool_q;
		cfg.pooled_h = div_pool(height_q, pool_q);
		cfg.pooled_w = div_pool(width_q, pool_q);
	end

	mpab_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg       (cfg),
		.cfg_clr   (cfg_we),
		.cmdq_count(cmd_count),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	mpab_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_in),
		.rd_en  (cmd_pop),
		.rd_data(cmd_out),
		.valid  (cmd_valid),
		.count  (cmd_count)
	);

	mpab_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd_valid(cmd_valid),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	// command queue never overfills
	a_cmdq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_count <= CMDQ_CNT_W'(CMDQ_DEPTH)) && !(cmd_push && cmd_count == CMDQ_CNT_W'(CMDQ_DEPTH)
		&& !cmd_pop))
		else $error("command queue overflow");

	// window offsets stay inside the window
	a_win_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({1'b0, result.window_row} < pool_q) && ({1'b0, result.window_col} < pool_q))
		else $error("window offset beyond pool size");

	// a flagged word is a forward word or the window's bottom right corner
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.last_of_run) |->
		((result.window_row == '0) && (result.window_col == '0)) ||
		(({1'b0, result.window_row} == pool_q - POOL_W'(1)) &&
		({1'b0, result.window_col} == pool_q - POOL_W'(1))))
		else $error("last word at wrong window position");

endmodule

>>> rtl/mpab_ram.sv
// ----------------------------------------------------------------------------
// mpab_ram: generic simple dual port ram
// one write port, one read port with registered read data, read first
// ----------------------------------------------------------------------------
module mpab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/mpab_front.sv
// ----------------------------------------------------------------------------
// mpab_front: input side of the max pool block
// tracks raster and pooled positions, folds window maxima, keeps argmax
// ----------------------------------------------------------------------------
module mpab_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  mpab_pkg::in_word_t                item,
	input  mpab_pkg::cfg_t                    cfg,
	input  logic                              cfg_clr,
	input  logic [mpab_pkg::CMDQ_CNT_W-1:0]   cmdq_count,
	output logic                              cmd_push,
	output mpab_pkg::cmd_t                    cmd
);
	import mpab_pkg::*;

	logic [ROW_W-1:0]  r_q;
	logic [COL_W-1:0]  c_q;
	logic [CHAN_W-1:0] l_q;
	logic [WIN_W-1:0]  wr_q, wc_q;
	logic [WROW_W-1:0] wrow_q;
	logic [WCOL_W-1:0] wcol_q;
	logic [CHAN_W-1:0] bl_q;
	logic [WCOL_W-1:0] bpc_q;
	logic [WROW_W-1:0] bpr_q;

	logic accept, fwd_in, fwd_live, bwd_live, take;
	logic l_last, c_last, r_last, wc_last, wr_last;
	logic bl_last, bpc_last, bpr_last;
	logic win_first, win_last;
	logic [OFF_W-1:0]   elem_off;
	logic [PART_AW-1:0] part_raddr;
	logic [ARG_AW-1:0]  fwd_ai, bwd_ai;

	logic                    v_s1, bwd_s1, first_s1, lastw_s1;
	logic signed [VAL_W-1:0] val_s1;
	logic [OFF_W-1:0]        off_s1;
	logic [PART_AW-1:0]      pi_s1;
	logic [ARG_AW-1:0]       ai_s1;
	logic                    pbyp_s1, abyp_s1;
	logic signed [VAL_W-1:0] pbyp_max_s1;
	logic [OFF_W-1:0]        pbyp_off_s1, abyp_off_s1;

	logic [PART_W-1:0]       part_rdata;
	logic [OFF_W-1:0]        arg_rdata;
	logic signed [VAL_W-1:0] cur_max, new_max;
	logic [OFF_W-1:0]        cur_off, new_off, arg_off;
	logic                    part_we, arg_we;

	assign full = ((CMDQ_CNT_W + 1)'(cmdq_count) + (CMDQ_CNT_W + 1)'(v_s1))
		>= (CMDQ_CNT_W + 1)'(CMDQ_DEPTH);
	assign accept = push & ~full;
	assign fwd_in = (item.operation == OP_FORWARD);

	assign fwd_live = ({1'b0, wrow_q} < cfg.pooled_h) && ({1'b0, wcol_q} < cfg.pooled_w);
	assign bwd_live = (cfg.pooled_h != '0) && (cfg.pooled_w != '0);
	assign take     = accept & (fwd_in ? fwd_live : bwd_live);

	assign l_last  = ({1'b0, l_q} == cfg.chans - DIM_W'(1));
	assign c_last  = ({1'b0, c_q} == cfg.width - DIM_W'(1));
	assign r_last  = ({1'b0, r_q} == cfg.height - DIM_W'(1));
	assign wc_last = ({1'b0, wc_q} == cfg.pool - POOL_W'(1));
	assign wr_last = ({1'b0, wr_q} == cfg.pool - POOL_W'(1));

	assign bl_last  = ({1'b0, bl_q} == cfg.chans - DIM_W'(1));
	assign bpc_last = ({1'b0, bpc_q} == cfg.pooled_w - PDIM_W'(1));
	assign bpr_last = ({1'b0, bpr_q} == cfg.pooled_h - PDIM_W'(1));

	assign win_first = (wr_q == '0) && (wc_q == '0);
	assign win_last  = wr_last & wc_last;
	assign elem_off  = OFF_W'(wr_q) * OFF_W'(cfg.pool) + OFF_W'(wc_q);

	assign part_raddr = {wcol_q, l_q};
	assign fwd_ai     = {wrow_q, wcol_q, l_q};
	assign bwd_ai     = {bpr_q, bpc_q, bl_q};

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0; c_q <= '0; l_q <= '0;
			wr_q <= '0; wc_q <= '0; wrow_q <= '0; wcol_q <= '0;
			bl_q <= '0; bpc_q <= '0; bpr_q <= '0;
		end else if (cfg_clr) begin
			r_q <= '0; c_q <= '0; l_q <= '0;
			wr_q <= '0; wc_q <= '0; wrow_q <= '0; wcol_q <= '0;
			bl_q <= '0; bpc_q <= '0; bpr_q <= '0;
		end else if (accept && fwd_in) begin
			if (l_last) begin
				l_q <= '0;
				if (c_last) begin
					c_q <= '0; wc_q <= '0; wcol_q <= '0;
					if (r_last) begin
						r_q <= '0; wr_q <= '0; wrow_q <= '0;
					end else begin
						r_q <= r_q + ROW_W'(1);
						if (wr_last) begin
							wr_q <= '0;
							wrow_q <= wrow_q + WROW_W'(1);
						end else begin
							wr_q <= wr_q + WIN_W'(1);
						end
					end
				end else begin
					c_q <= c_q + COL_W'(1);
					if (wc_last) begin
						wc_q <= '0;
						wcol_q <= wcol_q + WCOL_W'(1);
					end else begin
						wc_q <= wc_q + WIN_W'(1);
					end
				end
			end else begin
				l_q <= l_q + CHAN_W'(1);
			end
		end else if (accept && bwd_live) begin
			if (bl_last) begin
				bl_q <= '0;
				if (bpc_last) begin
					bpc_q <= '0;
					bpr_q <= bpr_last ? '0 : bpr_q + WROW_W'(1);
				end else begin
					bpc_q <= bpc_q + WCOL_W'(1);
				end
			end else begin
				bl_q <= bl_q + CHAN_W'(1);
			end
		end
	end

	// read stage: ram data arrives with the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bwd_s1      <= ~fwd_in;
			first_s1    <= win_first;
			lastw_s1    <= win_last;
			val_s1      <= item.value;
			off_s1      <= elem_off;
			pi_s1       <= part_raddr;
			ai_s1       <= fwd_in ? fwd_ai : bwd_ai;
			pbyp_s1     <= part_we && (pi_s1 == part_raddr);
			pbyp_max_s1 <= new_max;
			pbyp_off_s1 <= new_off;
			abyp_s1     <= arg_we && (ai_s1 == bwd_ai);
			abyp_off_s1 <= new_off;
		end
	end

	// running max update
	always_comb begin
		cur_max = pbyp_s1 ? pbyp_max_s1 : $signed(part_rdata[VAL_W-1:0]);
		cur_off = pbyp_s1 ? pbyp_off_s1 : part_rdata[PART_W-1:VAL_W];
		if (first_s1 || (val_s1 > cur_max)) begin
			new_max = val_s1;
			new_off = first_s1 ? '0 : off_s1;
		end else begin
			new_max = cur_max;
			new_off = cur_off;
		end
	end

	assign part_we = v_s1 & ~bwd_s1;
	assign arg_we  = v_s1 & ~bwd_s1 & lastw_s1;
	assign arg_off = abyp_s1 ? abyp_off_s1 : arg_rdata;

	assign cmd_push  = v_s1 & (bwd_s1 | lastw_s1);
	assign cmd.bwd   = bwd_s1;
	assign cmd.value = bwd_s1 ? val_s1 : new_max;
	assign cmd.off   = bwd_s1 ? arg_off : '0;

	mpab_ram #(
		.WIDTH(PART_W),
		.DEPTH(PART_DEPTH)
	) u_partial (
		.clk  (clk),
		.we   (part_we),
		.waddr(pi_s1),
		.wdata({new_off, new_max}),
		.re   (take & fwd_in),
		.raddr(part_raddr),
		.rdata(part_rdata)
	);

	mpab_ram #(
		.WIDTH(OFF_W),
		.DEPTH(ARG_DEPTH)
	) u_argmax (
		.clk  (clk),
		.we   (arg_we),
		.waddr(ai_s1),
		.wdata(new_off),
		.re   (take & ~fwd_in),
		.raddr(bwd_ai),
		.rdata(arg_rdata)
	);

endmodule

>>> rtl/mpab_cmdq.sv
// ----------------------------------------------------------------------------
// mpab_cmdq: short command queue between front and back
// register based, fill count exported for flow control
// ----------------------------------------------------------------------------
module mpab_cmdq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  mpab_pkg::cmd_t                  wr_data,
	input  logic                            rd_en,
	output mpab_pkg::cmd_t                  rd_data,
	output logic                            valid,
	output logic [mpab_pkg::CMDQ_CNT_W-1:0] count
);
	import mpab_pkg::*;

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_rd;

	assign valid   = (count_q != '0);
	assign do_rd   = rd_en & valid;
	assign rd_data = mem_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
					: wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
					: rd_ptr_q + CMDQ_PTR_W'(1);
			end
			if (wr_en && !do_rd) begin
				count_q <= count_q + CMDQ_CNT_W'(1);
			end else if (!wr_en && do_rd) begin
				count_q <= count_q - CMDQ_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/mpab_back.sv
// ----------------------------------------------------------------------------
// mpab_back: result side of the max pool block
// expands commands into result words and holds them in the output register
// ----------------------------------------------------------------------------
module mpab_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mpab_pkg::cfg_t      cfg,
	input  logic                cmd_valid,
	input  mpab_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  logic                pop,
	output mpab_pkg::out_word_t result
);
	import mpab_pkg::*;

	logic [WIN_W-1:0] j_q, k_q;
	logic [OFF_W-1:0] idx_q;
	logic             out_valid_q;
	out_word_t        out_q, nxt;
	logic             load, j_last, k_last, step_last;

	assign load      = cmd_valid & (~out_valid_q | pop);
	assign k_last    = ({1'b0, k_q} == cfg.pool - POOL_W'(1));
	assign j_last    = ({1'b0, j_q} == cfg.pool - POOL_W'(1));
	assign step_last = ~cmd.bwd | (j_last & k_last);
	assign cmd_pop   = load & step_last;

	always_comb begin
		if (cmd.bwd) begin
			nxt.result_value = (idx_q == cmd.off) ? cmd.value : '0;
			nxt.window_row   = j_q;
			nxt.window_col   = k_q;
			nxt.last_of_run  = j_last & k_last;
		end else begin
			nxt.result_value = cmd.value;
			nxt.window_row   = '0;
			nxt.window_col   = '0;
			nxt.last_of_run  = 1'b1;
		end
	end

	// window walk for gradient routing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q   <= '0;
			k_q   <= '0;
			idx_q <= '0;
		end else if (load && cmd.bwd) begin
			if (k_last) begin
				k_q <= '0;
				j_q <= j_last ? '0 : j_q + WIN_W'(1);
			end else begin
				k_q <= k_q + WIN_W'(1);
			end
			idx_q <= step_last ? '0 : idx_q + OFF_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= nxt;
		end
	end

	assign empty  = ~out_valid_q;
	assign result = out_q;

endmodule

>>> tb/max_pool_with_argmax_backprop_tb.sv
// ----------------------------------------------------------------------------
// max_pool_with_argmax_backprop_tb: self-checking bench for the max pool block
// A short table of activations and gradients, then random frames over many
// map shapes and window sizes, are pushed with bursty timing while the result
// side stalls on its own. A model of the pooling, the argmax store and the
// gradient routing predicts every word, and each popped word is compared.
// ----------------------------------------------------------------------------
module max_pool_with_argmax_backprop_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import mpab_pkg::*;

	localparam int REPORT_LIMIT  = 10;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RANDOM_WORDS  = 365;

	typedef enum logic {ROW_SETUP, ROW_WORD} row_kind_t;

	typedef enum logic [1:0] {SINK_STEADY, SINK_COIN, SINK_SLOW, SINK_HOLD} sink_mode_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [DIM_W-1:0]        height;
		logic [DIM_W-1:0]        width;
		logic [DIM_W-1:0]        chans;
		logic [POOL_W-1:0]       pool;
		logic                    op;
		logic signed [VAL_W-1:0] val;
		logic                    typed;
		logic signed [VAL_W-1:0] want;
	} plan_row_t;

	plan_row_t directed_plan [0:23] = '{
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd100,    1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  -16'sd100,   1'b0, 16'sd0},
		// one 2x2 window, an edge column and an edge row
		'{ROW_SETUP, 7'd3, 7'd3, 7'd1, 3'd2, OP_FORWARD,  16'sd0,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sh8000,   1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sh7fff,   1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd5,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sh7fff,   1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd0,      1'b1, 16'sh7fff},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  -16'sd1,     1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd1,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd2,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd3,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_BACKWARD, 16'sh8000,   1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_BACKWARD, 16'sh7fff,   1'b0, 16'sd0},
		// window larger than the map
		'{ROW_SETUP, 7'd2, 7'd2, 7'd1, 3'd4, OP_FORWARD,  16'sd0,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd9,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_BACKWARD, 16'sd9,      1'b0, 16'sd0},
		// all registers below range, all values tied
		'{ROW_SETUP, 7'd1, 7'd1, 7'd0, 3'd1, OP_FORWARD,  16'sd0,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd7,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd7,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd7,      1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_FORWARD,  16'sd7,      1'b1, 16'sd7},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_BACKWARD, -16'sd1,     1'b0, 16'sd0},
		'{ROW_WORD,  7'd0, 7'd0, 7'd0, 3'd0, OP_BACKWARD, 16'sd1,      1'b0, 16'sd0}
	};

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  push     = 1'b0;
	logic                  full;
	in_word_t              item     = '0;
	logic                  empty;
	logic                  pop      = 1'b0;
	out_word_t             result;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = REG_IN_HEIGHT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// pooling model state
	logic [DIM_W-1:0]        reg_h = 7'd64;
	logic [DIM_W-1:0]        reg_w = 7'd64;
	logic [DIM_W-1:0]        reg_c = 7'd64;
	logic [POOL_W-1:0]       reg_p = 3'd2;
	int unsigned             fwd_row, fwd_col, fwd_chan, bwd_pos;
	logic signed [VAL_W-1:0] run_max [PART_DEPTH];
	logic [OFF_W-1:0]        run_off [PART_DEPTH];
	logic [OFF_W-1:0]        argmax_mem [ARG_DEPTH];
	bit                      argmax_known [ARG_DEPTH];
	out_word_t               outputs_due [$];

	int unsigned failures, words_checked, words_sent, grads_sent, settings_used;
	int unsigned burst_left;
	bit          gapless;

	sink_mode_t  sink_mode = SINK_STEADY;
	int unsigned mode_left;

	max_pool_with_argmax_backprop u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic void geometry(output int unsigned p, output int unsigned h,
			output int unsigned wid, output int unsigned ch);
		p   = clip(reg_p, 2, POOL_HI);
		h   = clip(reg_h, 2, MAX_HEIGHT);
		wid = clip(reg_w, 2, MAX_WIDTH);
		ch  = clip(reg_c, 1, MAX_CHANNELS);
	endfunction

	function automatic int unsigned pooled_total();
		int unsigned p, h, wid, ch;
		geometry(p, h, wid, ch);
		return (h / p) * (wid / p) * ch;
	endfunction

	// argmax entry of the pooled output that the next gradient belongs to
	function automatic int unsigned grad_slot();
		int unsigned p, h, wid, ch, pw, rest;
		geometry(p, h, wid, ch);
		pw   = wid / p;
		rest = bwd_pos / ch;
		return ((rest / pw) * (MAX_WIDTH / 2) + rest % pw) * MAX_CHANNELS + bwd_pos % ch;
	endfunction

	function automatic bit grad_readable();
		if (pooled_total() == 0)
			return 1'b1;
		return argmax_known[grad_slot()];
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value(bit tie_heavy);
		if (tie_heavy && $urandom_range(0, 1) == 1)
			return $signed(VAL_W'($urandom_range(0, 3))) - 16'sd1;
		case ($urandom_range(0, 7))
			0: begin
				return 16'sh8000;
			end
			1: begin
				return 16'sh7fff;
			end
			default: begin
				return VAL_W'($urandom);
			end
		endcase
	endfunction

	task automatic pool_route(in_word_t word, bit typed, logic signed [VAL_W-1:0] want);
		int unsigned p, h, wid, ch, pi, ai, off, total, j, k;
		out_word_t o;
		geometry(p, h, wid, ch);
		if (word.operation == OP_FORWARD) begin
			if (fwd_row < (h / p) * p && fwd_col < (wid / p) * p) begin
				pi = (fwd_col / p) * MAX_CHANNELS + fwd_chan;
				if (fwd_row % p == 0 && fwd_col % p == 0) begin
					run_max[pi] = word.value;
					run_off[pi] = '0;
				end else if (word.value > run_max[pi]) begin
					run_max[pi] = word.value;
					run_off[pi] = OFF_W'((fwd_row % p) * p + fwd_col % p);
				end
				if (fwd_row % p == p - 1 && fwd_col % p == p - 1) begin
					ai = ((fwd_row / p) * (MAX_WIDTH / 2) + fwd_col / p) * MAX_CHANNELS
						+ fwd_chan;
					argmax_mem[ai]   = run_off[pi];
					argmax_known[ai] = 1'b1;
					o.result_value = typed ? want : run_max[pi];
					o.window_row   = '0;
					o.window_col   = '0;
					o.last_of_run  = 1'b1;
					outputs_due.push_back(o);
				end
			end
			fwd_chan++;
			if (fwd_chan >= ch) begin
				fwd_chan = 0;
				fwd_col++;
				if (fwd_col >= wid) begin
					fwd_col = 0;
					fwd_row = (fwd_row + 1 >= h) ? 0 : fwd_row + 1;
				end
			end
		end else begin
			total = pooled_total();
			if (total != 0) begin
				off = argmax_mem[grad_slot()];
				for (j = 0; j < p; j++) begin
					for (k = 0; k < p; k++) begin
						o.result_value = (j * p + k == off) ? word.value : '0;
						o.window_row   = WIN_W'(j);
						o.window_col   = WIN_W'(k);
						o.last_of_run  = (j == p - 1 && k == p - 1);
						outputs_due.push_back(o);
					end
				end
				bwd_pos = (bwd_pos + 1 >= total) ? 0 : bwd_pos + 1;
			end
		end
	endtask

	task automatic send(logic op, logic signed [VAL_W-1:0] v, bit typed,
			logic signed [VAL_W-1:0] want);
		in_word_t word;
		word.operation = op;
		word.value     = v;
		push <= 1'b1;
		item <= word;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pool_route(word, typed, want);
		words_sent++;
		if (op == OP_BACKWARD)
			grads_sent++;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			if (!gapless) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic quiesce();
		push <= 1'b0;
		while (outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [DIM_W-1:0] h, logic [DIM_W-1:0] wid,
			logic [DIM_W-1:0] c, logic [POOL_W-1:0] p);
		quiesce();
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_IN_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_idx  <= REG_IN_WIDTH;
		cfg_data <= wid;
		@(posedge clk);
		cfg_idx  <= REG_CHANNELS;
		cfg_data <= c;
		@(posedge clk);
		// upper data bits are don't care for the pool register
		cfg_idx  <= REG_POOL_SIZE;
		cfg_data <= {4'($urandom), p};
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_h = h;
		reg_w = wid;
		reg_c = c;
		reg_p = p;
		fwd_row  = 0;
		fwd_col  = 0;
		fwd_chan = 0;
		bwd_pos  = 0;
		settings_used++;
	endtask

	// zero counts mean one frame's worth of words and one gradient pass plus one or two words
	task automatic run_phase(logic [DIM_W-1:0] h, logic [DIM_W-1:0] wid,
			logic [DIM_W-1:0] c, logic [POOL_W-1:0] p, int unsigned fwd_n, int unsigned bwd_n);
		bit tie_heavy;
		int unsigned fp, fh, fw, fc;
		configure(h, wid, c, p);
		geometry(fp, fh, fw, fc);
		if (fwd_n == 0)
			fwd_n = fh * fw * fc;
		if (bwd_n == 0)
			bwd_n = pooled_total() + $urandom_range(1, 2);
		gapless   = ($urandom_range(0, 2) == 0);
		tie_heavy = $urandom_range(0, 1);
		repeat (fwd_n) begin
			if ($urandom_range(0, 11) == 0 && grad_readable())
				send(OP_BACKWARD, pick_value(1'b0), 1'b0, '0);
			else
				send(OP_FORWARD, pick_value(tie_heavy), 1'b0, '0);
		end
		repeat (bwd_n) begin
			if ($urandom_range(0, 11) == 0 || !grad_readable())
				send(OP_FORWARD, pick_value(tie_heavy), 1'b0, '0);
			else
				send(OP_BACKWARD, pick_value(1'b0), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (mode_left == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(40, 160);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (sink_mode)
			SINK_STEADY: pop <= 1'b1;
			SINK_COIN:   pop <= ($urandom_range(0, 1) == 1);
			SINK_SLOW:   pop <= ($urandom_range(0, 3) == 0);
			default:     pop <= ($urandom_range(0, 11) == 0);
		endcase
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && pop && !empty) begin
			if (outputs_due.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: word with nothing due: value %0d row %0d col %0d last %0b",
						$time, result.result_value, result.window_row, result.window_col,
						result.last_of_run);
			end else begin
				want = outputs_due.pop_front();
				words_checked++;
				if (result.result_value !== want.result_value
						|| result.window_row !== want.window_row
						|| result.window_col !== want.window_col
						|| result.last_of_run !== want.last_of_run) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("%0t: mismatch, expected value %0d row %0d col %0d last %0b",
							$time, want.result_value, want.window_row, want.window_col,
							want.last_of_run);
						$display("%0t:           got value %0d row %0d col %0d last %0b",
							$time, result.result_value, result.window_row,
							result.window_col, result.last_of_run);
					end
				end
			end
		end
	end

	initial begin
		int unsigned phase_no;
		int unsigned n;
		logic [POOL_W-1:0] p;
		burst_left = $urandom_range(1, 24);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_SETUP)
				configure(directed_plan[i].height, directed_plan[i].width,
					directed_plan[i].chans, directed_plan[i].pool);
			else
				send(directed_plan[i].op, directed_plan[i].val, directed_plan[i].typed,
					directed_plan[i].want);
		end

		// tallest map, widest map, most channels
		run_phase(7'd127, 7'd2, 7'd1, 3'd2, 24, 6);
		run_phase(7'd2, 7'd64, 7'd1, 3'd2, 68, 2);
		run_phase(7'd2, 7'd2, 7'd100, 3'd2, 194, 2);

		phase_no = 0;
		while (words_sent < RANDOM_WORDS) begin
			case (phase_no % 3)
				0: p = 3'd3;
				1: p = 3'd4;
				default: p = POOL_W'($urandom_range(0, 7));
			endcase
			run_phase(DIM_W'($urandom_range(0, 8)), DIM_W'($urandom_range(0, 8)),
				DIM_W'($urandom_range(0, 2)), p, 0, 0);
			phase_no++;
		end

		push <= 1'b0;
		for (n = 0; n < DRAIN_LIMIT && outputs_due.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (outputs_due.size() != 0) begin
			$display("%0d words still due at the end", outputs_due.size());
			failures += outputs_due.size();
		end

		$display("pushed %0d words (%0d gradients) across %0d map settings",
			words_sent, grads_sent, settings_used);
		$display("checked %0d result words, %0d failures", words_checked, failures);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d words still due", outputs_due.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/mpab_pkg.sv
rtl/mpab_ram.sv
rtl/mpab_front.sv
rtl/mpab_cmdq.sv
rtl/mpab_back.sv
rtl/max_pool_with_argmax_backprop.sv
tb/max_pool_with_argmax_backprop_tb.sv
